>>> rtl/mnvls_pkg.sv
// Shared constants for the minimum-norm vertical load split block.
package mnvls_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int LOAD_WIDTH_DEF  = 24;
    localparam int WEIGHT_WIDTH    = 16;
    localparam int NUM_FEET        = 4;

    localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_RESET = 16'd14988;

endpackage

>>> rtl/mnvls_mul.sv
// Two-stage signed multiplier built from four half-width partial products.
module mnvls_mul #(
    parameter int AW = 16,
    parameter int BW = 16
) (
    input  logic                 i_clk,
    input  logic signed [AW-1:0] i_a,
    input  logic signed [BW-1:0] i_b,
    output logic signed [AW+BW-1:0] o_p
);
    localparam int AL = AW / 2;
    localparam int AH = AW - AL;
    localparam int BL = BW / 2;
    localparam int BH = BW - BL;
    localparam int PW = AW + BW;

    logic signed [AH-1:0]     a_hi;
    logic signed [AL:0]       a_lo;
    logic signed [BH-1:0]     b_hi;
    logic signed [BL:0]       b_lo;
    logic signed [AH+BH-1:0]  r_hh;
    logic signed [AH+BL:0]    r_hl;
    logic signed [AL+BH:0]    r_lh;
    logic signed [AL+BL+1:0]  r_ll;
    logic signed [PW-1:0]     n_p;
    logic signed [PW-1:0]     r_p;

    // Low halves are zero-extended so that they multiply as unsigned parts.
    assign a_hi = i_a[AW-1:AL];
    assign a_lo = {1'b0, i_a[AL-1:0]};
    assign b_hi = i_b[BW-1:BL];
    assign b_lo = {1'b0, i_b[BL-1:0]};

    always_ff @(posedge i_clk) begin
        r_hh <= a_hi * b_hi;
        r_hl <= a_hi * b_lo;
        r_lh <= a_lo * b_hi;
        r_ll <= a_lo * b_lo;
    end

    assign n_p = (PW'(r_hh) <<< (AL + BL)) + (PW'(r_hl) <<< AL)
               + (PW'(r_lh) <<< BL) + PW'(r_ll);

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
    end

    assign o_p = r_p;

endmodule

>>> rtl/mnvls_div.sv
// Pipelined restoring divider with saturation and sign.
module mnvls_div #(
    parameter int NUMW = 100,
    parameter int DENW = 82,
    parameter int LW   = 24
) (
    input  logic                 i_clk,
    input  logic [NUMW-1:0]      i_num,
    input  logic                 i_neg,
    input  logic [DENW-1:0]      i_den,
    output logic signed [LW-1:0] o_load,
    output logic                 o_clip
);
    localparam int RW = ((NUMW > DENW + LW) ? NUMW : DENW + LW) + 1;
    localparam logic [LW-1:0] LIM = {1'b1, {(LW-1){1'b0}}};

    logic [RW-1:0]   r_rem [LW];
    logic [DENW-1:0] r_den [LW];
    logic [LW-1:0]   r_quo [LW+1];
    logic            r_neg [LW+1];
    logic            r_ovf [LW+1];
    logic [LW-1:0]   bound;
    logic [LW-1:0]   mag;
    logic            clip;
    logic [LW-1:0]   r_load;
    logic            r_clip;

    // Entry stage: a quotient that needs more than LW bits is flagged here.
    always_ff @(posedge i_clk) begin
        r_rem[0] <= RW'(i_num);
        r_den[0] <= i_den;
        r_quo[0] <= '0;
        r_neg[0] <= i_neg;
        r_ovf[0] <= RW'(i_num) >= (RW'(i_den) << LW);
    end

    // One quotient bit per stage, most significant first.
    for (genvar j = 0; j < LW; j++) begin : g_step
        localparam int SH = LW - 1 - j;
        logic [RW:0] trial;
        logic        take;

        assign trial = {1'b0, r_rem[j]} - ({1'b0, RW'(r_den[j])} << SH);
        assign take  = !trial[RW];

        always_ff @(posedge i_clk) begin
            r_quo[j+1] <= {r_quo[j][LW-2:0], take};
            r_neg[j+1] <= r_neg[j];
            r_ovf[j+1] <= r_ovf[j];
        end

        if (j < LW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_rem[j+1] <= take ? trial[RW-1:0] : r_rem[j];
                r_den[j+1] <= r_den[j];
            end
        end
    end

    assign bound = r_neg[LW] ? LIM : (LIM - LW'(1));
    assign clip  = r_ovf[LW] || (r_quo[LW] > bound);
    assign mag   = clip ? bound : r_quo[LW];

    always_ff @(posedge i_clk) begin
        r_load <= r_neg[LW] ? (LW'(0) - mag) : mag;
        r_clip <= clip;
    end

    assign o_load = r_load;
    assign o_clip = r_clip;

endmodule

>>> rtl/min_norm_vertical_load_split.sv
// Top level of the minimum-norm vertical load split pipeline.
//
// The block takes one set of four planar foot positions per clock cycle and
// returns the four vertical loads that carry the configured total weight with
// zero roll and pitch moment and the smallest sum of squared loads. An item is
// accepted whenever start is high; busy is always low because every stage
// advances each cycle. Each result is presented for exactly one cycle with
// o_done high and must be captured then, since the block has no way to hold
// it. The divider resolves one quotient bit per stage for each foot; the
// stages ahead of it centre the feet, sum the moments, run wide multiplies
// split into partial products, and add the rounding offset. If the feet are
// collinear or coincident the loads are zero and o_singular is set. Loads are
// rounded to nearest with ties away from zero, and saturate to the signed
// output range with o_clipped set. The total weight should be written only
// while no item is in flight.
module min_norm_vertical_load_split #(
    parameter int COORD_WIDTH = mnvls_pkg::COORD_WIDTH_DEF,
    parameter int LOAD_WIDTH  = mnvls_pkg::LOAD_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_cfg_we,
    input  logic [mnvls_pkg::WEIGHT_WIDTH-1:0]  i_cfg_wdata,
    input  logic signed [COORD_WIDTH-1:0]       i_fl_x,
    input  logic signed [COORD_WIDTH-1:0]       i_fl_y,
    input  logic signed [COORD_WIDTH-1:0]       i_fr_x,
    input  logic signed [COORD_WIDTH-1:0]       i_fr_y,
    input  logic signed [COORD_WIDTH-1:0]       i_hl_x,
    input  logic signed [COORD_WIDTH-1:0]       i_hl_y,
    input  logic signed [COORD_WIDTH-1:0]       i_hr_x,
    input  logic signed [COORD_WIDTH-1:0]       i_hr_y,
    output logic                                o_done,
    output logic signed [LOAD_WIDTH-1:0]        o_load_fl,
    output logic signed [LOAD_WIDTH-1:0]        o_load_fr,
    output logic signed [LOAD_WIDTH-1:0]        o_load_hl,
    output logic signed [LOAD_WIDTH-1:0]        o_load_hr,
    output logic                                o_singular,
    output logic                                o_clipped
);
    import mnvls_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int LW   = LOAD_WIDTH;
    localparam int SXW  = CW + 2;           // sum of four coordinates
    localparam int UW   = CW + 3;           // centred coordinate, scaled by four
    localparam int PW   = 2 * UW;           // one product of centred coordinates
    localparam int SW   = PW + 2;           // second moment over four feet
    localparam int DW   = 2 * SW + 1;       // Gram determinant
    localparam int PQW  = SXW + SW + 1;     // moment correction terms
    localparam int TW   = UW + PQW + 1;
    localparam int EW   = ((DW > TW + 2) ? DW : TW + 2) + 1;
    localparam int WSW  = WEIGHT_WIDTH + 1; // weight as a signed operand
    localparam int NW   = EW + WSW;
    localparam int NUMW = NW + 1;
    localparam int DENW = DW + 1;
    localparam int DIVL = LW + 2;           // divider latency
    localparam int LAT  = LW + 16;

    localparam logic signed [LW-1:0] LMAX = {1'b0, {(LW-1){1'b1}}};
    localparam logic signed [LW-1:0] LMIN = {1'b1, {(LW-1){1'b0}}};

    logic [WEIGHT_WIDTH-1:0] r_total_weight;
    logic [LAT-1:0]          r_vld;
    logic [DIVL:0]           r_sing_dly;

    logic signed [CW-1:0]    in_x [NUM_FEET];
    logic signed [CW-1:0]    in_y [NUM_FEET];

    logic signed [CW-1:0]    r1_x [NUM_FEET];
    logic signed [CW-1:0]    r1_y [NUM_FEET];
    logic signed [SXW-1:0]   r1_sx, r1_sy;

    logic signed [UW-1:0]    r2_u [NUM_FEET], r2_v [NUM_FEET];
    logic signed [SXW-1:0]   r2_sx, r2_sy;

    logic signed [PW-1:0]    r3_uu [NUM_FEET], r3_vv [NUM_FEET], r3_uv [NUM_FEET];
    logic signed [UW-1:0]    r3_u [NUM_FEET], r3_v [NUM_FEET];
    logic signed [SXW-1:0]   r3_sx, r3_sy;

    logic signed [SW-1:0]    r4_suu, r4_svv, r4_suv;
    logic signed [UW-1:0]    r4_u [NUM_FEET], r4_v [NUM_FEET];
    logic signed [SXW-1:0]   r4_sx, r4_sy;

    logic signed [UW-1:0]    r5_u [NUM_FEET], r5_v [NUM_FEET];
    logic signed [UW-1:0]    r6_u [NUM_FEET], r6_v [NUM_FEET];

    logic signed [2*SW-1:0]  m_uuvv, m_uvuv;
    logic signed [SXW+SW-1:0] m_sxvv, m_syuv, m_syuu, m_sxuv;

    logic signed [DW-1:0]    r7_d;
    logic signed [PQW-1:0]   r7_p, r7_q;
    logic signed [UW-1:0]    r7_u [NUM_FEET], r7_v [NUM_FEET];

    logic signed [UW+PQW-1:0] m_up [NUM_FEET], m_vq [NUM_FEET];
    logic signed [DW-1:0]    r8_d, r9_d;

    logic signed [EW-1:0]    r10_e [NUM_FEET];
    logic signed [DW-1:0]    r10_d;
    logic signed [WSW-1:0]   weight_s;

    logic signed [NW-1:0]    m_n [NUM_FEET];
    logic signed [DW-1:0]    r11_d, r12_d;

    logic signed [NW+1:0]    n_num [NUM_FEET];
    logic signed [NW+1:0]    d2_ext;
    logic [NUMW-1:0]         r13_num [NUM_FEET];
    logic                    r13_neg [NUM_FEET];
    logic [DENW-1:0]         r13_den;

    logic signed [LW-1:0]    dv_load [NUM_FEET];
    logic                    dv_clip [NUM_FEET];
    logic                    sing;

    logic signed [LW-1:0]    r_load [NUM_FEET];
    logic                    r_singular;
    logic                    r_clipped;

    assign busy = 1'b0;

    assign in_x[0] = i_fl_x;
    assign in_y[0] = i_fl_y;
    assign in_x[1] = i_fr_x;
    assign in_y[1] = i_fr_y;
    assign in_x[2] = i_hl_x;
    assign in_y[2] = i_hl_y;
    assign in_x[3] = i_hr_x;
    assign in_y[3] = i_hr_y;

    // Control state: weight register and the valid bits that follow each item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_weight <= WEIGHT_RESET;
            r_vld          <= '0;
        end else begin
            if (i_cfg_we) begin
                r_total_weight <= i_cfg_wdata;
            end
            r_vld <= {r_vld[LAT-2:0], start & ~busy};
        end
    end

    // Stages 1 to 4: centre the feet on their mean (scaled by four) and
    // accumulate the second moments of the centred positions.
    always_ff @(posedge i_clk) begin
        r1_x  <= in_x;
        r1_y  <= in_y;
        r1_sx <= SXW'(i_fl_x) + SXW'(i_fr_x) + SXW'(i_hl_x) + SXW'(i_hr_x);
        r1_sy <= SXW'(i_fl_y) + SXW'(i_fr_y) + SXW'(i_hl_y) + SXW'(i_hr_y);

        for (int f = 0; f < NUM_FEET; f++) begin
            r2_u[f] <= (UW'(r1_x[f]) <<< 2) - UW'(r1_sx);
            r2_v[f] <= (UW'(r1_y[f]) <<< 2) - UW'(r1_sy);
        end
        r2_sx <= r1_sx;
        r2_sy <= r1_sy;

        for (int f = 0; f < NUM_FEET; f++) begin
            r3_uu[f] <= r2_u[f] * r2_u[f];
            r3_vv[f] <= r2_v[f] * r2_v[f];
            r3_uv[f] <= r2_u[f] * r2_v[f];
        end
        r3_u  <= r2_u;
        r3_v  <= r2_v;
        r3_sx <= r2_sx;
        r3_sy <= r2_sy;

        r4_suu <= SW'(r3_uu[0]) + SW'(r3_uu[1]) + SW'(r3_uu[2]) + SW'(r3_uu[3]);
        r4_svv <= SW'(r3_vv[0]) + SW'(r3_vv[1]) + SW'(r3_vv[2]) + SW'(r3_vv[3]);
        r4_suv <= SW'(r3_uv[0]) + SW'(r3_uv[1]) + SW'(r3_uv[2]) + SW'(r3_uv[3]);
        r4_u   <= r3_u;
        r4_v   <= r3_v;
        r4_sx  <= r3_sx;
        r4_sy  <= r3_sy;

        // The centred coordinates wait here while the moment products form.
        r5_u <= r4_u;
        r5_v <= r4_v;
        r6_u <= r5_u;
        r6_v <= r5_v;
    end

    // Stages 5 and 6: determinant and cofactor products.
    mnvls_mul #(.AW(SW), .BW(SW)) u_mul_uuvv (
        .i_clk(i_clk), .i_a(r4_suu), .i_b(r4_svv), .o_p(m_uuvv));
    mnvls_mul #(.AW(SW), .BW(SW)) u_mul_uvuv (
        .i_clk(i_clk), .i_a(r4_suv), .i_b(r4_suv), .o_p(m_uvuv));
    mnvls_mul #(.AW(SXW), .BW(SW)) u_mul_sxvv (
        .i_clk(i_clk), .i_a(r4_sx), .i_b(r4_svv), .o_p(m_sxvv));
    mnvls_mul #(.AW(SXW), .BW(SW)) u_mul_syuv (
        .i_clk(i_clk), .i_a(r4_sy), .i_b(r4_suv), .o_p(m_syuv));
    mnvls_mul #(.AW(SXW), .BW(SW)) u_mul_syuu (
        .i_clk(i_clk), .i_a(r4_sy), .i_b(r4_suu), .o_p(m_syuu));
    mnvls_mul #(.AW(SXW), .BW(SW)) u_mul_sxuv (
        .i_clk(i_clk), .i_a(r4_sx), .i_b(r4_suv), .o_p(m_sxuv));

    // Stage 7: determinant D and the moment correction terms P and Q.
    always_ff @(posedge i_clk) begin
        r7_d <= DW'(m_uuvv) - DW'(m_uvuv);
        r7_p <= PQW'(m_sxvv) - PQW'(m_syuv);
        r7_q <= PQW'(m_syuu) - PQW'(m_sxuv);
        r7_u <= r6_u;
        r7_v <= r6_v;
        r8_d <= r7_d;
        r9_d <= r8_d;
    end

    // Stages 8 and 9: per-foot projections onto the correction terms.
    for (genvar f = 0; f < NUM_FEET; f++) begin : g_proj
        mnvls_mul #(.AW(UW), .BW(PQW)) u_mul_up (
            .i_clk(i_clk), .i_a(r7_u[f]), .i_b(r7_p), .o_p(m_up[f]));
        mnvls_mul #(.AW(UW), .BW(PQW)) u_mul_vq (
            .i_clk(i_clk), .i_a(r7_v[f]), .i_b(r7_q), .o_p(m_vq[f]));
    end

    // Stage 10: numerator factor D - 4 (u P + v Q) for each foot.
    always_ff @(posedge i_clk) begin
        for (int f = 0; f < NUM_FEET; f++) begin
            r10_e[f] <= EW'(r9_d)
                      - (EW'(TW'(m_up[f]) + TW'(m_vq[f])) <<< 2);
        end
        r10_d <= r9_d;
        r11_d <= r10_d;
        r12_d <= r11_d;
    end

    assign weight_s = {1'b0, r_total_weight};

    // Stages 11 and 12: scale by the total weight.
    for (genvar f = 0; f < NUM_FEET; f++) begin : g_wmul
        mnvls_mul #(.AW(EW), .BW(WSW)) u_mul_w (
            .i_clk(i_clk), .i_a(r10_e[f]), .i_b(weight_s), .o_p(m_n[f]));
    end

    // Stage 13: add half the divisor to the magnitude for round-to-nearest.
    assign d2_ext = (NW+2)'(r12_d) <<< 1;

    always_comb begin
        for (int f = 0; f < NUM_FEET; f++) begin
            n_num[f] = m_n[f][NW-1] ? (d2_ext - (NW+2)'(m_n[f]))
                                    : ((NW+2)'(m_n[f]) + d2_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int f = 0; f < NUM_FEET; f++) begin
            r13_num[f] <= n_num[f][NUMW-1:0];
            r13_neg[f] <= m_n[f][NW-1];
        end
        r13_den    <= {r12_d[DW-2:0], 2'b00};
        r_sing_dly <= {r_sing_dly[DIVL-1:0], r12_d == '0};
    end

    for (genvar f = 0; f < NUM_FEET; f++) begin : g_div
        mnvls_div #(.NUMW(NUMW), .DENW(DENW), .LW(LW)) u_div (
            .i_clk  (i_clk),
            .i_num  (r13_num[f]),
            .i_neg  (r13_neg[f]),
            .i_den  (r13_den),
            .o_load (dv_load[f]),
            .o_clip (dv_clip[f])
        );
    end

    // Output stage: a singular set of feet overrides the divider results.
    assign sing = r_sing_dly[DIVL];

    always_ff @(posedge i_clk) begin
        for (int f = 0; f < NUM_FEET; f++) begin
            r_load[f] <= sing ? '0 : dv_load[f];
        end
        r_singular <= sing;
        r_clipped  <= !sing && (dv_clip[0] || dv_clip[1] || dv_clip[2] || dv_clip[3]);
    end

    assign o_done     = r_vld[LAT-1];
    assign o_load_fl  = r_load[0];
    assign o_load_fr  = r_load[1];
    assign o_load_hl  = r_load[2];
    assign o_load_hr  = r_load[3];
    assign o_singular = r_singular;
    assign o_clipped  = r_clipped;

`ifndef ASSERT_OFF
    // A singular result never reports saturation.
    a_sing_no_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_singular && o_clipped))
        else $error("singular result also flagged as clipped");

    // A singular result carries all-zero loads.
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_singular) |-> (o_load_fl == '0 && o_load_fr == '0
                                    && o_load_hl == '0 && o_load_hr == '0))
        else $error("singular result with nonzero loads");

    // A clipped result has at least one load sitting on a range bound.
    a_clip_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_clipped) |->
            (o_load_fl == LMAX || o_load_fl == LMIN || o_load_fr == LMAX
             || o_load_fr == LMIN || o_load_hl == LMAX || o_load_hl == LMIN
             || o_load_hr == LMAX || o_load_hr == LMIN))
        else $error("clipped flag without a saturated load");

    // Every result traces back to an earlier accepted item.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, LAT))
        else $error("result without a matching accepted item");
`endif

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the minimum-norm vertical load split block.
`timescale 1ns / 1ps

module testbench;
    import mnvls_pkg::*;

    localparam int CW        = COORD_WIDTH_DEF;
    localparam int LW        = LOAD_WIDTH_DEF;
    // Forty pipeline stages at the default load width, plus some margin.
    localparam int LATENCY   = LW + 16;
    localparam int DRAIN     = LATENCY + 10;
    localparam int CYCLE_CAP = 400000;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic signed [LW-1:0] t_load;

    // One set of foot positions, in the order front-left, front-right,
    // hind-left, hind-right.
    typedef struct {
        t_coord x [4];
        t_coord y [4];
    } t_stance;

    typedef struct {
        t_load load [4];
        logic  singular;
        logic  clipped;
    } t_load_split;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic                    i_cfg_we = 1'b0;
    logic [WEIGHT_WIDTH-1:0] i_cfg_wdata = '0;
    t_coord                  i_fl_x = '0, i_fl_y = '0, i_fr_x = '0, i_fr_y = '0;
    t_coord                  i_hl_x = '0, i_hl_y = '0, i_hr_x = '0, i_hr_y = '0;
    logic                    o_done;
    t_load                   o_load_fl, o_load_fr, o_load_hl, o_load_hr;
    logic                    o_singular, o_clipped;

    min_norm_vertical_load_split dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fl_x      (i_fl_x),
        .i_fl_y      (i_fl_y),
        .i_fr_x      (i_fr_x),
        .i_fr_y      (i_fr_y),
        .i_hl_x      (i_hl_x),
        .i_hl_y      (i_hl_y),
        .i_hr_x      (i_hr_x),
        .i_hr_y      (i_hr_y),
        .o_done      (o_done),
        .o_load_fl   (o_load_fl),
        .o_load_fr   (o_load_fr),
        .o_load_hl   (o_load_hl),
        .o_load_hr   (o_load_hr),
        .o_singular  (o_singular),
        .o_clipped   (o_clipped)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // The testbench's own copy of the weight register, updated at each write.
    logic [WEIGHT_WIDTH-1:0] weight_model = WEIGHT_RESET;
    t_load_split             pending_loads [$];
    int unsigned             error_count = 0;
    int unsigned             cycle_count = 0;
    bit                      burst_mode = 1'b0;

    // Computes the exact load split. Coordinates are centred (scaled by four
    // so everything stays integer), the Gram determinant of the centred
    // positions is the common denominator, and each load is rounded once to
    // nearest with ties away from zero. 256-bit arithmetic is far wider than
    // any intermediate value can get.
    function automatic t_load_split split_loads(t_stance s, logic [WEIGHT_WIDTH-1:0] w);
        t_load_split       r;
        logic signed [255:0] px [4], py [4], cu [4], cv [4];
        logic signed [255:0] sum_x, sum_y, suu, svv, suv, gram, p, q, t, n, wt;
        logic [255:0]      mag, half, den, quo, bound;
        logic              neg;
        sum_x = '0;
        sum_y = '0;
        for (int i = 0; i < 4; i++) begin
            px[i] = s.x[i];
            py[i] = s.y[i];
            sum_x = sum_x + px[i];
            sum_y = sum_y + py[i];
        end
        suu = '0;
        svv = '0;
        suv = '0;
        for (int i = 0; i < 4; i++) begin
            cu[i] = 4 * px[i] - sum_x;
            cv[i] = 4 * py[i] - sum_y;
            suu = suu + cu[i] * cu[i];
            svv = svv + cv[i] * cv[i];
            suv = suv + cu[i] * cv[i];
        end
        gram = suu * svv - suv * suv;
        r.clipped = 1'b0;
        if (gram == 0) begin
            // Collinear or coincident feet: no unique split exists.
            for (int i = 0; i < 4; i++) r.load[i] = '0;
            r.singular = 1'b1;
            return r;
        end
        r.singular = 1'b0;
        p = sum_x * svv - sum_y * suv;
        q = sum_y * suu - sum_x * suv;
        wt = {240'd0, w};
        half = 2 * gram;
        den = 4 * gram;
        for (int i = 0; i < 4; i++) begin
            t = cu[i] * p + cv[i] * q;
            n = (gram - 4 * t) * wt;
            neg = n[255];
            mag = neg ? -n : n;
            quo = (mag + half) / den;
            bound = neg ? (256'd1 << (LW - 1)) : (256'd1 << (LW - 1)) - 1;
            if (quo > bound) begin
                quo = bound;
                r.clipped = 1'b1;
            end
            r.load[i] = neg ? t_load'(-quo) : t_load'(quo);
        end
        return r;
    endfunction

    // Gap before the next item: mostly none or short, a few long.
    function automatic int pick_gap();
        int roll;
        if (burst_mode) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(13, 40);
    endfunction

    // Presents one item, waits for it to be accepted, and queues its loads.
    // Called right after a rising edge; returns right after the accepting edge.
    task automatic send_item(t_stance s);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_fl_x <= s.x[0];
        i_fl_y <= s.y[0];
        i_fr_x <= s.x[1];
        i_fr_y <= s.y[1];
        i_hl_x <= s.x[2];
        i_hl_y <= s.y[2];
        i_hr_x <= s.x[3];
        i_hr_y <= s.y[3];
        // Inputs only move at rising edges, so busy at the falling edge is
        // what the next rising edge will see.
        forever begin
            @(negedge i_clk);
            if (!busy) break;
            @(posedge i_clk);
        end
        pending_loads.push_back(split_loads(s, weight_model));
        @(posedge i_clk);
    endtask

    // Stops sending and waits until every queued result has come back, plus
    // the pipeline depth.
    task automatic wait_idle();
        int guard;
        start <= 1'b0;
        guard = 0;
        while (pending_loads.size() != 0 && guard < 20 * LATENCY) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_weight(logic [WEIGHT_WIDTH-1:0] w);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        weight_model  = w;
    endtask

    function automatic t_coord rand_coord();
        return t_coord'($urandom_range(0, 65535));
    endfunction

    // A plausible stance: feet near the four corners of a body footprint.
    function automatic t_stance stance_near_corners();
        t_stance s;
        int half_len, half_wid, jit;
        half_len = $urandom_range(500, 16000);
        half_wid = $urandom_range(500, 12000);
        jit = $urandom_range(0, 400);
        for (int i = 0; i < 4; i++) begin
            s.x[i] = t_coord'((i < 2 ? half_len : -half_len)
                              + $signed($urandom_range(0, 2 * jit)) - jit);
            s.y[i] = t_coord'((i % 2 == 0 ? half_wid : -half_wid)
                              + $signed($urandom_range(0, 2 * jit)) - jit);
        end
        return s;
    endfunction

    // Four feet on one line; optionally one foot nudged off it by one code,
    // which makes the system nearly singular and the loads very large.
    function automatic t_stance stance_on_line(bit nudge);
        t_stance s;
        int bx, by, dx, dy, k;
        bx = $signed($urandom_range(0, 40000)) - 20000;
        by = $signed($urandom_range(0, 40000)) - 20000;
        dx = $signed($urandom_range(0, 2000)) - 1000;
        dy = $signed($urandom_range(0, 2000)) - 1000;
        for (int i = 0; i < 4; i++) begin
            k = $signed($urandom_range(0, 16)) - 8;
            s.x[i] = t_coord'(bx + k * dx);
            s.y[i] = t_coord'(by + k * dy);
        end
        if (nudge) begin
            k = $urandom_range(0, 3);
            if ($urandom_range(0, 1)) s.x[k] = t_coord'(s.x[k] + 1);
            else s.y[k] = t_coord'(s.y[k] - 1);
        end
        return s;
    endfunction

    function automatic t_stance stance_random();
        t_stance s;
        for (int i = 0; i < 4; i++) begin
            s.x[i] = rand_coord();
            s.y[i] = rand_coord();
        end
        return s;
    endfunction

    function automatic t_stance make_stance(int x0, int y0, int x1, int y1,
                                            int x2, int y2, int x3, int y3);
        t_stance s;
        s.x[0] = t_coord'(x0); s.y[0] = t_coord'(y0);
        s.x[1] = t_coord'(x1); s.y[1] = t_coord'(y1);
        s.x[2] = t_coord'(x2); s.y[2] = t_coord'(y2);
        s.x[3] = t_coord'(x3); s.y[3] = t_coord'(y3);
        return s;
    endfunction

    // Field extremes, a symmetric stance, coincident and collinear feet, a
    // nearly collinear stance that saturates, and a lopsided one.
    task automatic test_directed();
        send_item(make_stance(4000, 2000, 4000, -2000, -4000, 2000, -4000, -2000));
        send_item(make_stance(0, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_stance(100, 100, 100, 100, 100, 100, 100, 100));
        send_item(make_stance(0, 0, 1, 1, 2, 2, 3, 3));
        send_item(make_stance(-32768, 0, 32767, 0, 0, 0, 5, 0));
        send_item(make_stance(32767, 32767, 32767, -32768, -32768, 32767,
                              -32768, -32768));
        send_item(make_stance(-32768, -32768, -32768, -32768, -32768, -32768,
                              -32768, -32768));
        send_item(make_stance(-32768, 0, 32767, 0, 0, 1, 0, 0));
        send_item(make_stance(-32768, 0, 32767, 0, 0, 0, 0, 1));
        send_item(make_stance(32767, 32767, -32768, -32768, 0, 0, 1, 0));
        send_item(make_stance(10000, 3000, 9000, -3500, -8000, 3200, -12000, -2900));
        send_item(make_stance(1, 0, 0, 1, -1, 0, 0, -1));
        send_item(make_stance(16384, 8192, 16384, -8192, -16384, 8192, 30000, 0));
        send_item(make_stance(5, -5, 5, -5, -7, 7, 9, 9));
    endtask

    task automatic run_random(int count);
        int roll;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 55) send_item(stance_near_corners());
            else if (roll < 75) send_item(stance_random());
            else if (roll < 87) send_item(stance_on_line(1'b0));
            else send_item(stance_on_line(1'b1));
        end
    endtask

    // Back-to-back items with no gaps, to fill the pipeline.
    task automatic test_burst(int count);
        burst_mode = 1'b1;
        run_random(count);
        burst_mode = 1'b0;
    endtask

    task automatic test_weight_extremes();
        write_weight(16'd0);
        test_directed();
        run_random(60);
        write_weight(16'hFFFF);
        test_directed();
        run_random(150);
        write_weight(16'd1);
        run_random(60);
    endtask

    task automatic test_random_weights();
        for (int ph = 0; ph < 5; ph++) begin
            write_weight(16'($urandom_range(0, 65535)));
            run_random(100);
            test_burst(30);
        end
        write_weight(WEIGHT_RESET);
        run_random(40);
    endtask

    // Results are sampled at the falling edge, halfway through their cycle.
    always @(negedge i_clk) begin
        t_load_split want;
        t_load       got [4];
        if (i_rst_n && o_done) begin
            got = '{o_load_fl, o_load_fr, o_load_hl, o_load_hr};
            if (pending_loads.size() == 0) begin
                $display("%0t: unexpected result, loads %0d %0d %0d %0d", $time,
                         got[0], got[1], got[2], got[3]);
                error_count++;
            end else begin
                want = pending_loads.pop_front();
                for (int i = 0; i < 4; i++) begin
                    if (got[i] !== want.load[i]) begin
                        $display("%0t: load %0d expected %0d actual %0d", $time, i,
                                 want.load[i], got[i]);
                        error_count++;
                    end
                end
                if (o_singular !== want.singular) begin
                    $display("%0t: singular expected %0b actual %0b", $time,
                             want.singular, o_singular);
                    error_count++;
                end
                if (o_clipped !== want.clipped) begin
                    $display("%0t: clipped expected %0b actual %0b", $time,
                             want.clipped, o_clipped);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // The reset weight is used first, before any write.
        test_directed();
        run_random(150);
        test_burst(40);
        test_weight_extremes();
        test_random_weights();
        wait_idle();
        if (error_count == 0 && pending_loads.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
